// File: hdl/wvsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvsa_pkg
// Shared constants, types and register codes of the windowed sample averager.
// ----------------------------------------------------------------------------
package wvsa_pkg;

    localparam int WINDOW      = 8;
    localparam int IDX_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + IDX_W;
    localparam int FIELD_CNT_W = 7;
    localparam int DIV_CNT_W   = $clog2(SAMPLE_W + 1);
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_INVALID = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MARKER    = 8'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0]    lower_limit;
        logic [SAMPLE_W-1:0]    upper_limit;
        logic [FIELD_CNT_W-1:0] allowed_invalid;
        logic [SAMPLE_W-1:0]    empty_marker;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic scan;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic used_zero;
    } t_sts;

    typedef struct packed {
        logic                   window_empty;
        logic                   too_many_invalid;
        logic [FIELD_CNT_W-1:0] averaged_count;
        logic [FIELD_CNT_W-1:0] invalid_count;
        logic                   sample_ok;
        logic [SAMPLE_W-1:0]    average_mv;
    } t_result;

endpackage

// File: hdl/windowed_valid_sample_averager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_valid_sample_averager_core
// Moving average over a ring window with per-sample range validity.
// ----------------------------------------------------------------------------
// Each request carries one millivolt sample. It is range checked, written into
// the window, and then the window is scanned one entry per clock to form the
// invalid count, the averaged count and the sum; a one-bit-per-clock divider
// then forms the average in sixteen steps, which are skipped when no entry
// qualifies for the average. A new sample is taken only once the last result
// has gone into the output register, and that load is held up only while an
// earlier result still waits on the result side.
// A finished result sits in the output register while the next sample is
// taken. Configuration writes are accepted at any time but belong to idle
// periods; writes to unknown indices are ignored.
// ----------------------------------------------------------------------------
module windowed_valid_sample_averager_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // s_tdata: [15:0] sample_mv
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wvsa_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: [15:0] average_mv, [16] sample_ok, [23:17] invalid_count,
    //          [30:24] averaged_count, [31] too_many_invalid, [32] window_empty
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wvsa_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wvsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wvsa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wvsa_pkg::*;

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_result;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_limit     <= '0;
            r_cfg.upper_limit     <= '1;
            r_cfg.allowed_invalid <= FIELD_CNT_W'(2);
            r_cfg.empty_marker    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LOWER_LIMIT:     r_cfg.lower_limit     <= i_cfg_data;
                REG_UPPER_LIMIT:     r_cfg.upper_limit     <= i_cfg_data;
                REG_ALLOWED_INVALID: r_cfg.allowed_invalid <= i_cfg_data[FIELD_CNT_W-1:0];
                REG_EMPTY_MARKER:    r_cfg.empty_marker    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wvsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wvsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample_mv (s_tdata[SAMPLE_W-1:0]),
        .o_result    (w_result)
    );

    assign m_tdata = {(OUT_TDATA_W - $bits(t_result))'(0), w_result};

endmodule

// File: hdl/wvsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvsa_ctrl
// Sequencer: accept, window scan, divider run and output register handshake.
// ----------------------------------------------------------------------------
module wvsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  wvsa_pkg::t_sts i_sts,
    output wvsa_pkg::t_cmd o_cmd
);
    import wvsa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_m_tvalid;
    logic   w_out_free;

    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid = r_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = i_sts.used_zero ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready   = i_rst_n;
                o_cmd.accept = i_s_tvalid && i_rst_n;
            end
            S_SCAN: o_cmd.scan      = 1'b1;
            S_PREP: o_cmd.div_start = 1'b1;
            S_DIV:  o_cmd.div_step  = 1'b1;
            S_OUT:  o_cmd.load_out  = w_out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hdl/wvsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvsa_dp
// Sample window, range check, serial accumulation and bit-serial divider.
// ----------------------------------------------------------------------------
module wvsa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wvsa_pkg::t_cfg                 i_cfg,
    input  wvsa_pkg::t_cmd                 i_cmd,
    output wvsa_pkg::t_sts                 o_sts,
    input  logic [wvsa_pkg::SAMPLE_W-1:0]  i_sample_mv,
    output wvsa_pkg::t_result              o_result
);
    import wvsa_pkg::*;

    logic [SAMPLE_W-1:0]  r_store [WINDOW];
    logic                 r_mark  [WINDOW];
    logic [IDX_W-1:0]     r_wp;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_ok;
    logic [CNT_W-1:0]     r_bad;
    logic [CNT_W-1:0]     r_used;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_rem;
    logic [SAMPLE_W-1:0]  r_quot;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    t_result              r_result;

    logic                 w_ok;
    logic [CNT_W:0]       w_trial;
    logic [CNT_W:0]       w_used_ext;
    logic                 w_ge;
    logic [CNT_W-1:0]     n_rem;
    logic [SAMPLE_W-1:0]  w_entry;
    logic                 w_entry_bad;

    assign w_ok = !((i_sample_mv < i_cfg.lower_limit) || (i_sample_mv > i_cfg.upper_limit));

    assign w_entry     = r_store[r_idx];
    assign w_entry_bad = r_mark[r_idx];

    // one restoring division step
    assign w_trial    = {r_rem, r_quot[SAMPLE_W-1]};
    assign w_used_ext = {1'b0, r_used};
    assign w_ge       = w_trial >= w_used_ext;
    assign n_rem      = w_ge ? CNT_W'(w_trial - w_used_ext) : w_trial[CNT_W-1:0];

    assign o_sts.scan_last = r_idx == IDX_W'(WINDOW - 1);
    assign o_sts.div_last  = r_div_cnt == DIV_CNT_W'(1);
    assign o_sts.used_zero = r_used == '0;

    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_store[i] <= '0;
                r_mark[i]  <= 1'b0;
            end
            r_wp <= '0;
        end else if (i_cmd.accept) begin
            r_store[r_wp] <= i_sample_mv;
            r_mark[r_wp]  <= !w_ok;
            r_wp          <= (r_wp == IDX_W'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ok   <= w_ok;
            r_idx  <= '0;
            r_bad  <= '0;
            r_used <= '0;
            r_sum  <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            if (w_entry_bad) begin
                r_bad <= r_bad + 1'b1;
            end else if (w_entry != i_cfg.empty_marker) begin
                r_sum  <= r_sum + SUM_W'(w_entry);
                r_used <= r_used + 1'b1;
            end
        end
    end

    // quotient fits the sample width, so the upper sum bits start as remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem     <= CNT_W'(r_sum[SUM_W-1:SAMPLE_W]);
            r_quot    <= r_sum[SAMPLE_W-1:0];
            r_div_cnt <= DIV_CNT_W'(SAMPLE_W);
        end else if (i_cmd.div_step) begin
            r_rem     <= n_rem;
            r_quot    <= {r_quot[SAMPLE_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_result.average_mv       <= r_quot;
            r_result.sample_ok        <= r_ok;
            r_result.invalid_count    <= FIELD_CNT_W'(r_bad);
            r_result.averaged_count   <= FIELD_CNT_W'(r_used);
            r_result.too_many_invalid <= FIELD_CNT_W'(r_bad) > i_cfg.allowed_invalid;
            r_result.window_empty     <= r_used == '0;
        end
    end

endmodule
